FILE: rtl/dbb_pkg.sv
// shared types and constants of the deskewed bounding box core
// no dependencies; every other file refers to it by scoped names
package dbb_pkg;

   localparam int INCLINE_WIDTH  = 12;
   localparam int MASK_WIDTH     = 16;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int CSR_IDX_WIDTH  = 1;
   localparam int PROD_WIDTH     = 28;   // 12 x 16 signed product
   localparam int QUOT_WIDTH     = 17;   // product / 2048, truncated
   localparam int SKEW_SHIFT     = 11;   // divide by 2048
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_WIDTH     = 2;
   localparam int QCNT_WIDTH     = 3;
   localparam int MIN_INIT       = 32000;
   localparam int MAX_INIT       = -16000;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_INCLINE   = 1'b0,
      CSR_KIND_MASK = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] orig_row;
      logic signed [15:0] orig_col;
      logic [14:0]        rect_width;
      logic [14:0]        rect_height;
      logic [15:0]        kind_flags;
      logic               last;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] box_col;
      logic signed [15:0] box_row;
      logic signed [15:0] box_width;
      logic signed [15:0] box_height;
   } rsp_word_type;

   // classified item with skew products, as it travels through the queue
   typedef struct packed {
      logic                         counted;
      logic                         last;
      logic signed [15:0]           orig_row;
      logic signed [15:0]           orig_col;
      logic [14:0]                  rect_width;
      logic [14:0]                  rect_height;
      logic signed [PROD_WIDTH-1:0] prod_row;   // incline * orig_row
      logic signed [PROD_WIDTH-1:0] prod_col;   // incline * orig_col
   } work_type;

   // queue handshake toward one side
   typedef struct packed {
      logic     valid;
      work_type word;
   } work_xfer_type;

endpackage

FILE: rtl/dbb_front.sv
// front end: configuration registers, accept, kind classification and skew products
// depends on dbb_pkg
module dbb_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_en,
   input  logic [dbb_pkg::CSR_IDX_WIDTH-1:0]      csr_index,
   input  logic [dbb_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  dbb_pkg::req_word_type                  req_word,
   output dbb_pkg::work_xfer_type                 push,
   input  logic                                   queue_full
);

   logic signed [dbb_pkg::INCLINE_WIDTH-1:0] incline_ff;
   logic [dbb_pkg::MASK_WIDTH-1:0]           kind_mask_ff;
   logic                                     f1_valid_ff, f1_valid_in;
   dbb_pkg::work_type                        f1_word_ff, f1_word_in;
   logic                                     load;
   logic                                     moved;

   always_ff @(posedge clock) begin
      if (reset) begin
         incline_ff   <= '0;
         kind_mask_ff <= '1;
      end else if (csr_write_en) begin
         case (csr_index)
            dbb_pkg::CSR_INCLINE:   incline_ff   <= csr_wdata[dbb_pkg::INCLINE_WIDTH-1:0];
            dbb_pkg::CSR_KIND_MASK: kind_mask_ff <= csr_wdata[dbb_pkg::MASK_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign moved     = f1_valid_ff && !queue_full;
   assign req_stall = f1_valid_ff && queue_full;
   assign load      = req_valid && !req_stall;

   always_comb begin
      f1_word_in.counted     = |(req_word.kind_flags & kind_mask_ff);
      f1_word_in.last        = req_word.last;
      f1_word_in.orig_row    = req_word.orig_row;
      f1_word_in.orig_col    = req_word.orig_col;
      f1_word_in.rect_width  = req_word.rect_width;
      f1_word_in.rect_height = req_word.rect_height;
      f1_word_in.prod_row    = dbb_pkg::PROD_WIDTH'(incline_ff)
                             * dbb_pkg::PROD_WIDTH'(req_word.orig_row);
      f1_word_in.prod_col    = dbb_pkg::PROD_WIDTH'(incline_ff)
                             * dbb_pkg::PROD_WIDTH'(req_word.orig_col);
      if (load) begin
         f1_valid_in = 1'b1;
      end else if (moved) begin
         f1_valid_in = 1'b0;
      end else begin
         f1_valid_in = f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         f1_word_ff <= f1_word_in;
      end
   end

   assign push.valid = moved;
   assign push.word  = f1_word_ff;

endmodule

FILE: rtl/dbb_queue.sv
// short queue of classified words between front and back end
// depends on dbb_pkg
module dbb_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  dbb_pkg::work_xfer_type push,
   output logic                   full,
   output dbb_pkg::work_xfer_type head,
   input  logic                   pop
);

   dbb_pkg::work_type                entry_ff [dbb_pkg::QUEUE_DEPTH];
   logic [dbb_pkg::QPTR_WIDTH-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [dbb_pkg::QCNT_WIDTH-1:0]   count_ff, count_in;

   assign full       = (count_ff == dbb_pkg::QCNT_WIDTH'(dbb_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.word  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.word;
      end
   end

endmodule

FILE: rtl/dbb_back.sv
// back end: deskew of the corner, bound tracking and the result register
// depends on dbb_pkg
module dbb_back #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dbb_pkg::work_xfer_type head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dbb_pkg::rsp_word_type  rsp_word
);

   localparam int WIDE = COORD_WIDTH + 18;
   localparam logic signed [COORD_WIDTH-1:0] MIN_RELOAD = COORD_WIDTH'(dbb_pkg::MIN_INIT);
   localparam logic signed [COORD_WIDTH-1:0] MAX_RELOAD = COORD_WIDTH'(dbb_pkg::MAX_INIT);
   localparam logic signed [dbb_pkg::PROD_WIDTH-1:0] ROUND_BIAS =
      dbb_pkg::PROD_WIDTH'((1 << dbb_pkg::SKEW_SHIFT) - 1);

   logic                                  advance;

   // deskew stage
   logic signed [dbb_pkg::PROD_WIDTH-1:0] sum_row, sum_col;
   logic signed [dbb_pkg::QUOT_WIDTH-1:0] quot_row, quot_col;
   logic signed [COORD_WIDTH-1:0]         drow, dcol;
   logic signed [COORD_WIDTH-1:0]         row_in, col_in;
   logic signed [WIDE-1:0]                far_row_in, far_col_in;
   logic                                  b1_valid_ff, b1_valid_in;
   logic                                  b1_counted_ff, b1_last_ff;
   logic signed [COORD_WIDTH-1:0]         b1_row_ff, b1_col_ff;
   logic signed [WIDE-1:0]                b1_far_row_ff, b1_far_col_ff;

   // bound stage
   logic signed [COORD_WIDTH-1:0] min_col_ff, min_row_ff, max_col_ff, max_row_ff;
   logic signed [COORD_WIDTH-1:0] min_col_in, min_row_in, max_col_in, max_row_in;
   logic signed [COORD_WIDTH-1:0] min_col_new, min_row_new, max_col_new, max_row_new;
   logic                          take;
   logic                          rsp_valid_ff, rsp_valid_in;
   dbb_pkg::rsp_word_type         rsp_word_ff, rsp_word_in;

   assign advance = !(rsp_valid_ff && rsp_stall);
   assign pop     = advance && head.valid;

   always_comb begin
      // divide by 2048 truncating toward zero
      sum_row = head.word.prod_row + (head.word.prod_row[dbb_pkg::PROD_WIDTH-1] ? ROUND_BIAS : '0);
      sum_col = head.word.prod_col + (head.word.prod_col[dbb_pkg::PROD_WIDTH-1] ? ROUND_BIAS : '0);
      quot_row = dbb_pkg::QUOT_WIDTH'(sum_row >>> dbb_pkg::SKEW_SHIFT);
      quot_col = dbb_pkg::QUOT_WIDTH'(sum_col >>> dbb_pkg::SKEW_SHIFT);
      dcol = COORD_WIDTH'(WIDE'(quot_row));
      drow = COORD_WIDTH'(WIDE'(quot_col));
      row_in = COORD_WIDTH'(WIDE'(head.word.orig_row) - WIDE'(drow));
      col_in = COORD_WIDTH'(WIDE'(head.word.orig_col) + WIDE'(dcol));
      far_row_in = WIDE'(row_in) + WIDE'(head.word.rect_height);
      far_col_in = WIDE'(col_in) + WIDE'(head.word.rect_width);
      b1_valid_in = advance ? head.valid : b1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= b1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b1_counted_ff <= head.word.counted;
         b1_last_ff    <= head.word.last;
         b1_row_ff     <= row_in;
         b1_col_ff     <= col_in;
         b1_far_row_ff <= far_row_in;
         b1_far_col_ff <= far_col_in;
      end
   end

   assign take = advance && b1_valid_ff;

   always_comb begin
      min_col_new = min_col_ff;
      min_row_new = min_row_ff;
      max_col_new = max_col_ff;
      max_row_new = max_row_ff;
      if (b1_counted_ff) begin
         if (min_col_ff > b1_col_ff) begin
            min_col_new = b1_col_ff;
         end
         if (min_row_ff > b1_row_ff) begin
            min_row_new = b1_row_ff;
         end
         // far edge compared at full precision, stored wrapped
         if (WIDE'(max_col_ff) < b1_far_col_ff) begin
            max_col_new = COORD_WIDTH'(b1_far_col_ff);
         end
         if (WIDE'(max_row_ff) < b1_far_row_ff) begin
            max_row_new = COORD_WIDTH'(b1_far_row_ff);
         end
      end

      min_col_in = min_col_ff;
      min_row_in = min_row_ff;
      max_col_in = max_col_ff;
      max_row_in = max_row_ff;
      if (take) begin
         if (b1_last_ff) begin
            min_col_in = MIN_RELOAD;
            min_row_in = MIN_RELOAD;
            max_col_in = MAX_RELOAD;
            max_row_in = MAX_RELOAD;
         end else begin
            min_col_in = min_col_new;
            min_row_in = min_row_new;
            max_col_in = max_col_new;
            max_row_in = max_row_new;
         end
      end

      rsp_word_in.box_col    = 16'(WIDE'(min_col_new));
      rsp_word_in.box_row    = 16'(WIDE'(min_row_new));
      rsp_word_in.box_width  = 16'(WIDE'(max_col_new) - WIDE'(min_col_new));
      rsp_word_in.box_height = 16'(WIDE'(max_row_new) - WIDE'(min_row_new));
      rsp_valid_in = advance ? (b1_valid_ff && b1_last_ff) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_col_ff   <= MIN_RELOAD;
         min_row_ff   <= MIN_RELOAD;
         max_col_ff   <= MAX_RELOAD;
         max_row_ff   <= MAX_RELOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_col_ff   <= min_col_in;
         min_row_ff   <= min_row_in;
         max_col_ff   <= max_col_in;
         max_row_ff   <= max_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && b1_last_ff) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

FILE: rtl/deskewed_bounding_box_core.sv
// top level of the deskewed bounding box core: front end, queue and back end
// depends on dbb_pkg, dbb_front, dbb_queue and dbb_back
//
// One text line arrives as a stream of glyph rectangle words on req_, one
// rectangle per word, the final one flagged by last. Rectangles whose kind
// flags share a bit with kind_mask are deskewed (row minus incline*col/2048,
// column plus incline*row/2048, truncated toward zero) and folded into the
// line's bounding box; each last word yields one box word on rsp_ and reloads
// the bounds, so a line with no counted rectangle reports the reload box.
// The core takes one word per clock while req_stall is low. A word is
// accepted into the front stage (kind test and the two 12 x 16 skew products),
// passes a four-deep queue, is deskewed in the first back stage and folded
// into the bounds in the second, which also loads the result register. A
// stall on rsp_ freezes only the back end; the queue keeps absorbing words
// until it and the front stage are full, and then req_stall rises. Write
// incline and kind_mask only between lines, with the core drained.
module deskewed_bounding_box_core #(
   parameter int COORD_WIDTH = 16   // width of the tracked bounds, 16 to 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration writes
   input  logic                               csr_write_en,
   input  logic [dbb_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [dbb_pkg::CSR_DATA_WIDTH-1:0] csr_wdata,
   // rectangle words
   input  logic                               req_valid,
   output logic                               req_stall,
   input  dbb_pkg::req_word_type              req_word,
   // box words
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output dbb_pkg::rsp_word_type              rsp_word
);

   dbb_pkg::work_xfer_type push;   // front stage into the queue
   dbb_pkg::work_xfer_type head;   // queue head toward the back end
   logic                   queue_full;
   logic                   pop;

   // accept, kind test, skew products
   dbb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .push         (push),
      .queue_full   (queue_full)
   );

   // decouples the front from a stalled back end
   dbb_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   // deskew, bound tracking, result register
   dbb_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

FILE: rtl/dbb_checker.sv
// port-level checks of the deskewed bounding box core, bound to the top level
// depends on dbb_pkg and deskewed_bounding_box_core
module dbb_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input dbb_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input dbb_pkg::rsp_word_type rsp_word
);

   logic [3:0] lines_open_ff, lines_open_in;
   logic       line_in, line_out;

   assign line_in  = req_valid && !req_stall && req_word.last;
   assign line_out = rsp_valid && !rsp_stall;

   always_comb begin
      lines_open_in = lines_open_ff;
      if (line_in && !line_out) begin
         lines_open_in = lines_open_ff + 1'b1;
      end else if (line_out && !line_in) begin
         lines_open_in = lines_open_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lines_open_ff <= '0;
      end else begin
         lines_open_ff <= lines_open_in;
      end
   end

   // a box word needs a last rectangle accepted before it
   a_box_has_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> lines_open_ff != '0)
      else $error("box word without an open line");

   // a stalled box word holds
   a_box_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled box word changed");

   // reset empties the core
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("core not empty after reset");

endmodule

bind deskewed_bounding_box_core dbb_checker u_dbb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
